// ===== sv/kalman_cv_tracker_2d_unit_assert.svh =====
// assertion macros for the tracker checks
`ifndef KALMAN_CV_TRACKER_2D_UNIT_ASSERT_SVH
`define KALMAN_CV_TRACKER_2D_UNIT_ASSERT_SVH

// condition implies consequence in the same cycle
`define KCTR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define KCTR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/kctr_pkg.sv =====
// shared types, constants and fixed point helpers of the tracker
package kctr_pkg;

  localparam int Tracks   = 2;
  localparam int FracBits = 16;
  localparam int IntBits  = 31 - FracBits;
  localparam int QuoW     = 31;
  localparam int RshW     = 65 - FracBits;
  localparam int Words    = 20;
  localparam int LastOp   = 30;
  localparam int AddrW    = 5;

  typedef enum logic [2:0] {
    REG_TIME_STEP    = 3'd0,
    REG_PROC_VAR_POS = 3'd1,
    REG_PROC_VAR_VEL = 3'd2,
    REG_MEAS_VAR_POS = 3'd3,
    REG_INIT_VEL     = 3'd4,
    REG_INIT_VAR_X   = 3'd5,
    REG_INIT_VAR_Y   = 3'd6,
    REG_INIT_VAR_VEL = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [30:0]        time_step;
    logic [30:0]        process_var_pos;
    logic [30:0]        process_var_vel;
    logic [30:0]        meas_var_pos;
    logic signed [31:0] init_velocity;
    logic [30:0]        init_var_x;
    logic [30:0]        init_var_y;
    logic [30:0]        init_var_vel;
  } cfg_t;

  typedef struct packed {
    logic               track_id;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
  } meas_t;

  typedef struct packed {
    logic               out_track;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
  } est_t;

  typedef struct packed {
    logic busy;
    logic div_busy;
    logic mem_we;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fff_ffff;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // saturating 64 bit add or subtract
  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic sub);
    logic [64:0] s;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // round half up, then drop the fraction bits
  function automatic logic signed [RshW-1:0] rshr(input logic signed [63:0] v);
    logic [64:0] t;
    t = {v[63], v} + (65'd1 << (FracBits - 1));
    return t[64:FracBits];
  endfunction

endpackage

// ===== sv/kctr_stream_if.sv =====
// valid/ready channel with a typed payload
interface kctr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/kctr_regs.sv =====
// configuration registers behind the apb port
module kctr_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kctr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output kctr_pkg::cfg_t             cfg_o
);

  kctr_pkg::cfg_t     cfg_q;
  kctr_pkg::reg_idx_e idx;
  logic               wr;

  assign idx    = kctr_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step       <= 31'd6554;
      cfg_q.process_var_pos <= 31'd655;
      cfg_q.process_var_vel <= 31'd6554;
      cfg_q.meas_var_pos    <= 31'd4096;
      cfg_q.init_velocity   <= 32'sd51511;
      cfg_q.init_var_x      <= 31'd13435;
      cfg_q.init_var_y      <= 31'd13271;
      cfg_q.init_var_vel    <= 31'd1638;
    end else if (wr) begin
      unique case (idx)
        kctr_pkg::REG_TIME_STEP:    cfg_q.time_step       <= pwdata[30:0];
        kctr_pkg::REG_PROC_VAR_POS: cfg_q.process_var_pos <= pwdata[30:0];
        kctr_pkg::REG_PROC_VAR_VEL: cfg_q.process_var_vel <= pwdata[30:0];
        kctr_pkg::REG_MEAS_VAR_POS: cfg_q.meas_var_pos    <= pwdata[30:0];
        kctr_pkg::REG_INIT_VEL:     cfg_q.init_velocity   <= $signed(pwdata);
        kctr_pkg::REG_INIT_VAR_X:   cfg_q.init_var_x      <= pwdata[30:0];
        kctr_pkg::REG_INIT_VAR_Y:   cfg_q.init_var_y      <= pwdata[30:0];
        kctr_pkg::REG_INIT_VAR_VEL: cfg_q.init_var_vel    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      kctr_pkg::REG_TIME_STEP:    prdata = {1'b0, cfg_q.time_step};
      kctr_pkg::REG_PROC_VAR_POS: prdata = {1'b0, cfg_q.process_var_pos};
      kctr_pkg::REG_PROC_VAR_VEL: prdata = {1'b0, cfg_q.process_var_vel};
      kctr_pkg::REG_MEAS_VAR_POS: prdata = {1'b0, cfg_q.meas_var_pos};
      kctr_pkg::REG_INIT_VEL:     prdata = cfg_q.init_velocity;
      kctr_pkg::REG_INIT_VAR_X:   prdata = {1'b0, cfg_q.init_var_x};
      kctr_pkg::REG_INIT_VAR_Y:   prdata = {1'b0, cfg_q.init_var_y};
      kctr_pkg::REG_INIT_VAR_VEL: prdata = {1'b0, cfg_q.init_var_vel};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/kctr_div.sv =====
// gain divider: one quotient bit per cycle, saturating fixed point quotient
module kctr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [63:0]        den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  localparam int CntW = $clog2(kctr_pkg::QuoW);

  logic                     busy_q, done_q;
  logic [CntW-1:0]          cnt_q;
  logic [63:0]              r_q, den_q, mag;
  logic [kctr_pkg::QuoW-1:0] sh_q, q_q;
  logic                     neg_q, ovf_q, ge;
  logic [64:0]              rr;

  assign mag = num_i[63] ? (64'd0 - num_i) : num_i;
  assign rr  = {r_q, sh_q[kctr_pkg::QuoW-1]};
  assign ge  = rr >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(kctr_pkg::QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[63];
      ovf_q <= ({kctr_pkg::IntBits'(0), mag} >= {den_i, kctr_pkg::IntBits'(0)});
      r_q   <= mag >> kctr_pkg::IntBits;
      sh_q  <= {mag[kctr_pkg::IntBits-1:0], kctr_pkg::FracBits'(0)};
      q_q   <= '0;
    end else if (busy_q) begin
      r_q  <= ge ? 64'(rr - {1'b0, den_q}) : rr[63:0];
      q_q  <= {q_q[kctr_pkg::QuoW-2:0], ge};
      sh_q <= sh_q << 1;
    end
  end

  always_comb begin
    if (ovf_q) quo_o = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else       quo_o = neg_q ? (32'sd0 - {1'b0, q_q}) : {1'b0, q_q};
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== sv/kctr_core.sv =====
// track memory, working registers, shared multiplier and update sequencer
module kctr_core #(
  parameter int TRACKS = kctr_pkg::Tracks
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kctr_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kctr_pkg::meas_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kctr_pkg::est_t    out_data_o,
  output kctr_pkg::stat_t   stat_o
);

  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int AW    = TW + 5;
  localparam int Depth = TRACKS * 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_WRITE = 7'b0000100,
    S_PREP  = 7'b0001000,
    S_CALC  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]        mem_q [Depth];
  logic [31:0]        rdata_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata;

  logic [TRACKS-1:0]  started_q;
  logic [TW-1:0]      in_trk, trk_q;
  logic               trk_ok, accept;
  logic [4:0]         cnt_q, op_q;
  logic [1:0]         ph_q;
  logic               ovalid_q;
  kctr_pkg::est_t     out_q;

  logic signed [31:0] wk_q [kctr_pkg::Words];
  logic signed [31:0] k_q [8];
  logic signed [31:0] mx_q, my_q, ex_q, ey_q, s00_q, s11_q;
  logic signed [63:0] det_q, prod_q, first_q, mul, res;
  logic signed [31:0] ma, mb, xnew, pnew;
  logic signed [kctr_pkg::RshW-1:0] rsh;

  logic [4:0] gi, xi, pi, xsel;
  logic       is_pred, is_det, is_gain, is_xcor, is_pcor, det_pos, last_ph;
  logic       div_start, div_busy, div_done;
  logic signed [31:0] div_quo;

  assign in_trk  = TW'(in_data_i.track_id);
  assign trk_ok  = ({31'd0, in_data_i.track_id} < 32'(TRACKS));
  assign accept  = in_valid_i && (state_q == S_IDLE);

  assign gi = op_q - 5'd3;
  assign xi = op_q - 5'd11;
  assign pi = op_q - 5'd15;
  assign is_pred = (op_q < 5'd2);
  assign is_det  = (op_q == 5'd2);
  assign is_gain = (op_q > 5'd2) && (op_q < 5'd11);
  assign is_xcor = (op_q > 5'd10) && (op_q < 5'd15);
  assign is_pcor = (op_q > 5'd14);
  assign det_pos = (det_q > 64'sd0);
  assign last_ph = (ph_q == 2'd2);

  // multiplier operands, first pair on phase 0, second on phase 1
  always_comb begin
    ma = '0;
    mb = '0;
    if (is_pred) begin
      if (ph_q == 2'd0) begin
        ma = wk_q[{4'd1, op_q[0]}];
        mb = $signed({1'b0, cfg_i.time_step});
      end
    end else if (is_det) begin
      ma = (ph_q == 2'd0) ? s00_q : wk_q[5'd5];
      mb = (ph_q == 2'd0) ? s11_q : wk_q[5'd8];
    end else if (is_gain) begin
      unique case ({gi[0], ph_q[0]})
        2'b00: begin ma = wk_q[5'd4 + {1'b0, gi[2:1], 2'b00}]; mb = s11_q; end
        2'b01: begin ma = wk_q[5'd5 + {1'b0, gi[2:1], 2'b00}]; mb = wk_q[5'd8]; end
        2'b10: begin ma = wk_q[5'd5 + {1'b0, gi[2:1], 2'b00}]; mb = s00_q; end
        default: begin ma = wk_q[5'd4 + {1'b0, gi[2:1], 2'b00}]; mb = wk_q[5'd5]; end
      endcase
    end else if (is_xcor) begin
      ma = k_q[{xi[1:0], ph_q[0]}];
      mb = ph_q[0] ? ey_q : ex_q;
    end else begin
      ma = k_q[{pi[3:2], ph_q[0]}];
      mb = wk_q[(ph_q[0] ? 5'd8 : 5'd4) + {3'd0, pi[1:0]}];
    end
  end

  assign mul  = ma * mb;
  assign res  = kctr_pkg::sadd64(first_q, prod_q, is_det || is_gain);
  assign rsh  = kctr_pkg::rshr(res);
  assign xsel = is_pred ? {4'd0, op_q[0]} : {3'd0, xi[1:0]};
  assign xnew = kctr_pkg::sat32(66'(wk_q[xsel]) + 66'(rsh));
  assign pnew = kctr_pkg::sat32(66'(wk_q[5'd4 + pi]) - 66'(rsh));

  assign div_start = (state_q == S_CALC) && last_ph && is_gain && det_pos;

  kctr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (res),
    .den_i   (det_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = {trk_q, cnt_q};
    wdata = wk_q[cnt_q];
    raddr = {trk_q, cnt_q};
    if (state_q == S_WRITE) begin
      we = 1'b1;
    end else if ((state_q == S_CALC) && last_ph && is_xcor) begin
      we    = 1'b1;
      waddr = {trk_q, 3'd0, xi[1:0]};
      wdata = xnew;
    end else if ((state_q == S_CALC) && last_ph && is_pcor) begin
      we    = 1'b1;
      waddr = {trk_q, 5'd4 + pi};
      wdata = pnew;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept && trk_ok) state_d = started_q[in_trk] ? S_LOAD : S_WRITE;
      S_LOAD:  if (cnt_q == 5'(kctr_pkg::Words)) state_d = S_PREP;
      S_WRITE: if (cnt_q == 5'(kctr_pkg::Words - 1)) state_d = S_IDLE;
      S_PREP:  if (ph_q == 2'd1) state_d = S_CALC;
      S_CALC: begin
        if (last_ph) begin
          if (is_gain && det_pos) state_d = S_DIV;
          else if (op_q == 5'(kctr_pkg::LastOp)) state_d = S_DONE;
        end
      end
      S_DIV:   if (div_done) state_d = S_CALC;
      S_DONE:  if (!ovalid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= '0;
      cnt_q     <= '0;
      op_q      <= '0;
      ph_q      <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          ph_q  <= '0;
          if (accept && trk_ok) started_q[in_trk] <= 1'b1;
        end
        S_LOAD, S_WRITE: cnt_q <= cnt_q + 1'b1;
        S_PREP: begin
          ph_q <= (ph_q == 2'd1) ? 2'd0 : ph_q + 1'b1;
          op_q <= '0;
        end
        S_CALC: begin
          if (last_ph) begin
            ph_q <= '0;
            if (!(is_gain && det_pos)) op_q <= op_q + 1'b1;
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        S_DIV:  if (div_done) op_q <= op_q + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          trk_q <= in_trk;
          mx_q  <= in_data_i.meas_x;
          my_q  <= in_data_i.meas_y;
          // off-diagonal covariance words start at zero
          for (int n = 4; n < kctr_pkg::Words; n++) begin
            if (n != 4 && n != 9 && n != 14 && n != 19) wk_q[n] <= '0;
          end
          wk_q[0]  <= in_data_i.meas_x;
          wk_q[1]  <= in_data_i.meas_y;
          wk_q[2]  <= cfg_i.init_velocity;
          wk_q[3]  <= cfg_i.init_velocity;
          wk_q[4]  <= $signed({1'b0, cfg_i.init_var_x});
          wk_q[9]  <= $signed({1'b0, cfg_i.init_var_y});
          wk_q[14] <= $signed({1'b0, cfg_i.init_var_vel});
          wk_q[19] <= $signed({1'b0, cfg_i.init_var_vel});
        end
      end
      S_LOAD: if (cnt_q != 5'd0) wk_q[cnt_q - 5'd1] <= $signed(rdata_q);
      S_PREP: begin
        if (ph_q == 2'd0) begin
          wk_q[4]  <= kctr_pkg::sat32(66'(wk_q[4]) + 66'(cfg_i.process_var_pos));
          wk_q[9]  <= kctr_pkg::sat32(66'(wk_q[9]) + 66'(cfg_i.process_var_pos));
          wk_q[14] <= kctr_pkg::sat32(66'(wk_q[14]) + 66'(cfg_i.process_var_vel));
          wk_q[19] <= kctr_pkg::sat32(66'(wk_q[19]) + 66'(cfg_i.process_var_vel));
        end else begin
          s00_q <= kctr_pkg::sat32(66'(wk_q[4]) + 66'(cfg_i.meas_var_pos));
          s11_q <= kctr_pkg::sat32(66'(wk_q[9]) + 66'(cfg_i.meas_var_pos));
        end
      end
      S_CALC: begin
        unique case (ph_q)
          2'd0: prod_q <= mul;
          2'd1: begin
            first_q <= prod_q;
            prod_q  <= mul;
          end
          default: begin
            if (is_pred || is_xcor) wk_q[xsel] <= xnew;
            if (is_det) begin
              det_q <= res;
              ex_q  <= kctr_pkg::sat32(66'(mx_q) - 66'(wk_q[0]));
              ey_q  <= kctr_pkg::sat32(66'(my_q) - 66'(wk_q[1]));
            end
            // a non-positive innovation determinant leaves the gain at zero
            if (is_gain && !det_pos) k_q[gi[2:0]] <= '0;
          end
        endcase
      end
      S_DIV: if (div_done) k_q[gi[2:0]] <= div_quo;
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          out_q.out_track <= 1'(trk_q);
          out_q.est_x     <= wk_q[0];
          out_q.est_y     <= wk_q[1];
          out_q.est_vx    <= wk_q[2];
          out_q.est_vy    <= wk_q[3];
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = ovalid_q;
  assign out_data_o      = out_q;
  assign stat_o.busy     = (state_q != S_IDLE);
  assign stat_o.div_busy = div_busy;
  assign stat_o.mem_we   = we;

endmodule

// ===== sv/kalman_cv_tracker_2d_unit.sv =====
// top level of the two-dimensional constant-velocity tracker
// Tracks a position and velocity per track in signed Q16.16 with a Kalman filter.
// Each measurement beat on meas_i belongs to one track; the first beat of a track
// seeds its state and covariance and gives no estimate (one memory write per
// state word), every later beat runs predict and correct and gives one estimate
// beat on est_o. An update reads the 20 state words from the track memory, adds
// the noise terms, runs 31 product pairs on the single 32x32 multiplier and up to
// 8 gain divisions in the one-bit-per-cycle divider. One measurement is in work at
// a time; a finished estimate waits in the output register while the next
// measurement is taken.
module kalman_cv_tracker_2d_unit #(
  parameter int TRACKS = kctr_pkg::Tracks
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  kctr_stream_if.sink                meas_i,
  kctr_stream_if.source              est_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kctr_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  kctr_pkg::cfg_t  cfg;
  kctr_pkg::stat_t stat;
  kctr_pkg::meas_t meas;
  kctr_pkg::est_t  est;

  assign meas        = meas_i.payload;
  assign est_o.payload = est;

  kctr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kctr_core #(
    .TRACKS (TRACKS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (meas_i.valid),
    .in_ready_o  (meas_i.ready),
    .in_data_i   (meas),
    .out_valid_o (est_o.valid),
    .out_ready_i (est_o.ready),
    .out_data_o  (est),
    .stat_o      (stat)
  );

`include "kalman_cv_tracker_2d_unit_assert.svh"

  // a taken beat for a live track starts work at once
  `KCTR_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, meas_i.valid && meas_i.ready && ({31'd0, meas.track_id} < 32'(TRACKS)), stat.busy && !meas_i.ready, "beat taken but sequencer idle")
  // an estimate only appears at the end of an update
  `KCTR_ASSERT_NOW(a_est_from_update, clk_i, rst_ni, $rose(est_o.valid), $past(stat.busy), "estimate without update")
  // divider and memory writes belong to a running update
  `KCTR_ASSERT_NOW(a_div_in_update, clk_i, rst_ni, stat.div_busy || stat.mem_we, stat.busy, "datapath active while idle")

endmodule

// ===== verif/tb_kalman_cv_tracker_2d_unit.sv =====
// self-checking testbench of the 2d constant-velocity tracker: random measurements, scored estimates
module tb_kalman_cv_tracker_2d_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 20000;
  localparam int HoldCycles  = 3000;
  localparam int SettleCycles = 400;
  localparam int PhaseItems  = 87;
  localparam int Phases      = 5;

  class est_scoreboard;
    kctr_pkg::cfg_t cfg;
    bit     started[kctr_pkg::Tracks];
    int     pos_vel[kctr_pkg::Tracks][4];
    int     cov[kctr_pkg::Tracks][16];
    kctr_pkg::est_t est_q[$];
    int     errors;
    int     n_meas;
    int     n_est;

    function new();
      cfg.time_step       = 31'd6554;
      cfg.process_var_pos = 31'd655;
      cfg.process_var_vel = 31'd6554;
      cfg.meas_var_pos    = 31'd4096;
      cfg.init_velocity   = 32'sd51511;
      cfg.init_var_x      = 31'd13435;
      cfg.init_var_y      = 31'd13271;
      cfg.init_var_vel    = 31'd1638;
      foreach (started[i]) started[i] = 1'b0;
      errors = 0;
      n_meas = 0;
      n_est  = 0;
    endfunction

    function void set_reg(kctr_pkg::reg_idx_e idx, logic [31:0] val);
      case (idx)
        kctr_pkg::REG_TIME_STEP:    cfg.time_step       = val[30:0];
        kctr_pkg::REG_PROC_VAR_POS: cfg.process_var_pos = val[30:0];
        kctr_pkg::REG_PROC_VAR_VEL: cfg.process_var_vel = val[30:0];
        kctr_pkg::REG_MEAS_VAR_POS: cfg.meas_var_pos    = val[30:0];
        kctr_pkg::REG_INIT_VEL:     cfg.init_velocity   = val;
        kctr_pkg::REG_INIT_VAR_X:   cfg.init_var_x      = val[30:0];
        kctr_pkg::REG_INIT_VAR_Y:   cfg.init_var_y      = val[30:0];
        kctr_pkg::REG_INIT_VAR_VEL: cfg.init_var_vel    = val[30:0];
        default: ;
      endcase
    endfunction

    function int clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    function longint add_sat(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'h8000_0000_0000_0000
                                                          : 64'h7fff_ffff_ffff_ffff;
      return s;
    endfunction

    function longint sub_sat(longint a, longint b);
      longint s;
      s = a - b;
      if (a[63] != b[63] && s[63] != a[63]) return a[63] ? 64'h8000_0000_0000_0000
                                                          : 64'h7fff_ffff_ffff_ffff;
      return s;
    endfunction

    // round half up then drop fraction bits
    function longint round_shift(longint v);
      longint half;
      half = longint'(1) << (kctr_pkg::FracBits - 1);
      if (v > 64'sh7fff_ffff_ffff_ffff - half) v = 64'sh7fff_ffff_ffff_ffff - half;
      v = v + half;
      return v >>> kctr_pkg::FracBits;
    endfunction

    // gain entry: magnitude truncated toward zero, den > 0
    function int gain_div(longint num, longint den);
      longint unsigned n, d, q, r;
      n = num < 0 ? longint'(64'd0) - num : num;
      d = den;
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << (31 - kctr_pkg::FracBits))) begin
        q = 64'd1 << 31;
      end else begin
        for (int k = 0; k < kctr_pkg::FracBits; k++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
          end
        end
      end
      return clip32(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function void note_meas(kctr_pkg::meas_t m);
      int     t;
      longint xp[4];
      longint pp[16];
      longint kg[8];
      int     pn[16];
      longint s00, s01, s10, s11, det, ex, ey, c0, c1, k0, k1, acc;
      kctr_pkg::est_t e;
      t = m.track_id;
      n_meas++;
      if (!started[t]) begin
        pos_vel[t][0] = m.meas_x;
        pos_vel[t][1] = m.meas_y;
        pos_vel[t][2] = cfg.init_velocity;
        pos_vel[t][3] = cfg.init_velocity;
        for (int i = 0; i < 16; i++) cov[t][i] = 0;
        cov[t][0]  = int'(cfg.init_var_x);
        cov[t][5]  = int'(cfg.init_var_y);
        cov[t][10] = int'(cfg.init_var_vel);
        cov[t][15] = int'(cfg.init_var_vel);
        started[t] = 1'b1;
        return;
      end
      xp[0] = clip32(longint'(pos_vel[t][0]) +
                     round_shift(longint'(pos_vel[t][2]) * longint'(cfg.time_step)));
      xp[1] = clip32(longint'(pos_vel[t][1]) +
                     round_shift(longint'(pos_vel[t][3]) * longint'(cfg.time_step)));
      xp[2] = pos_vel[t][2];
      xp[3] = pos_vel[t][3];
      for (int i = 0; i < 16; i++) pp[i] = cov[t][i];
      pp[0]  = clip32(pp[0] + longint'(cfg.process_var_pos));
      pp[5]  = clip32(pp[5] + longint'(cfg.process_var_pos));
      pp[10] = clip32(pp[10] + longint'(cfg.process_var_vel));
      pp[15] = clip32(pp[15] + longint'(cfg.process_var_vel));
      s00 = clip32(pp[0] + longint'(cfg.meas_var_pos));
      s01 = pp[1];
      s10 = pp[4];
      s11 = clip32(pp[5] + longint'(cfg.meas_var_pos));
      det = sub_sat(s00 * s11, s01 * s10);
      for (int i = 0; i < 4; i++) begin
        c0 = pp[i*4];
        c1 = pp[i*4+1];
        if (det > 0) begin
          kg[i*2]   = gain_div(sub_sat(c0 * s11, c1 * s10), det);
          kg[i*2+1] = gain_div(sub_sat(c1 * s00, c0 * s01), det);
        end else begin
          kg[i*2]   = 0;
          kg[i*2+1] = 0;
        end
      end
      ex = clip32(longint'(m.meas_x) - xp[0]);
      ey = clip32(longint'(m.meas_y) - xp[1]);
      for (int i = 0; i < 4; i++) begin
        k0 = kg[i*2];
        k1 = kg[i*2+1];
        pos_vel[t][i] = clip32(xp[i] + round_shift(add_sat(k0 * ex, k1 * ey)));
        for (int j = 0; j < 4; j++) begin
          acc = add_sat(k0 * pp[j], k1 * pp[4+j]);
          pn[i*4+j] = clip32(pp[i*4+j] - round_shift(acc));
        end
      end
      for (int i = 0; i < 16; i++) cov[t][i] = pn[i];
      e.out_track = m.track_id;
      e.est_x  = pos_vel[t][0];
      e.est_y  = pos_vel[t][1];
      e.est_vx = pos_vel[t][2];
      e.est_vy = pos_vel[t][3];
      est_q.insert(est_q.size(), e);
    endfunction

    function void check_est(kctr_pkg::est_t a);
      kctr_pkg::est_t x;
      n_est++;
      if (est_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected estimate beat: track %0d x %0d y %0d",
                                   a.out_track, a.est_x, a.est_y);
        return;
      end
      x = est_q.pop_front();
      if (a.out_track !== x.out_track || a.est_x !== x.est_x || a.est_y !== x.est_y ||
          a.est_vx !== x.est_vx || a.est_vy !== x.est_vy) begin
        errors++;
        if (errors <= 10) begin
          $display("estimate %0d mismatch: exp trk %0d x %0d y %0d vx %0d vy %0d",
                   n_est, x.out_track, x.est_x, x.est_y, x.est_vx, x.est_vy);
          $display("  got trk %0d x %0d y %0d vx %0d vy %0d",
                   a.out_track, a.est_x, a.est_y, a.est_vx, a.est_vy);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [kctr_pkg::AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  kctr_stream_if #(.payload_t(kctr_pkg::meas_t)) meas_if ();
  kctr_stream_if #(.payload_t(kctr_pkg::est_t))  est_if ();

  kalman_cv_tracker_2d_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .meas_i  (meas_if),
    .est_o   (est_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  est_scoreboard sb = new();
  int  idle_cycles = 0;
  int  cfg_writes = 0;
  bit  held = 1'b0;
  int  track_pos[kctr_pkg::Tracks][2];

  always #5 clk_i = ~clk_i;

  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    meas_if.valid <= 1'b0;
    meas_if.payload <= '0;
    est_if.ready <= 1'b0;
  end

  // monitors: sampled at the edge, before any update of this step lands
  always @(posedge clk_i) begin
    if (rst_ni && meas_if.valid && meas_if.ready) sb.note_meas(meas_if.payload);
    if (rst_ni && est_if.valid && est_if.ready) sb.check_est(est_if.payload);
  end

  always @(posedge clk_i) begin
    if ((meas_if.valid && meas_if.ready) || (est_if.valid && est_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus one long hold-off once results are flowing
  initial begin
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (!held && sb.n_est >= 60) begin
        held = 1'b1;
        est_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        case (mode)
          0: est_if.ready <= 1'b1;
          1: est_if.ready <= $urandom_range(0, 1);
          default: est_if.ready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  task automatic write_reg(kctr_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= kctr_pkg::AddrW'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic write_all(logic [31:0] dt, logic [31:0] qp, logic [31:0] qv,
                           logic [31:0] r, logic [31:0] v0, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] vv);
    write_reg(kctr_pkg::REG_TIME_STEP, dt);
    write_reg(kctr_pkg::REG_PROC_VAR_POS, qp);
    write_reg(kctr_pkg::REG_PROC_VAR_VEL, qv);
    write_reg(kctr_pkg::REG_MEAS_VAR_POS, r);
    write_reg(kctr_pkg::REG_INIT_VEL, v0);
    write_reg(kctr_pkg::REG_INIT_VAR_X, vx);
    write_reg(kctr_pkg::REG_INIT_VAR_Y, vy);
    write_reg(kctr_pkg::REG_INIT_VAR_VEL, vv);
  endtask

  // valid stays high between back-to-back beats of a burst
  task automatic send_meas(logic trk, logic [31:0] mx, logic [31:0] my);
    kctr_pkg::meas_t m;
    m.track_id = trk;
    m.meas_x = mx;
    m.meas_y = my;
    meas_if.valid <= 1'b1;
    meas_if.payload <= m;
    do @(posedge clk_i); while (!meas_if.ready);
  endtask

  task automatic pause_sender(int cycles);
    meas_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    pause_sender(1);
    while (sb.est_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_meas();
    int t;
    t = $urandom_range(0, kctr_pkg::Tracks - 1);
    if ($urandom_range(0, 9) == 0) begin
      send_meas(t[0], $urandom, $urandom);
    end else begin
      // target moves smoothly, measurement carries small noise
      track_pos[t][0] += $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      track_pos[t][1] += $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      send_meas(t[0], track_pos[t][0] + $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000,
                track_pos[t][1] + $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
    end
  endtask

  initial begin
    int burst;
    foreach (track_pos[i]) begin
      track_pos[i][0] = 0;
      track_pos[i][1] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // track seeds with extreme initial variances and a negative initial velocity
    write_all(32'd6554, 32'd655, 32'd6554, 32'd4096, -32'sd51511, 32'd0,
              32'h7fff_ffff, 32'd1638);

    // directed: extreme positions on both tracks, first beat of each seeds it
    send_meas(1'b0, 32'h7fff_ffff, 32'h8000_0000);
    send_meas(1'b1, 32'h8000_0000, 32'h7fff_ffff);
    send_meas(1'b0, 32'd0, 32'd0);
    send_meas(1'b1, 32'd0, 32'd0);
    send_meas(1'b0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_meas(1'b1, 32'h8000_0000, 32'h8000_0000);
    send_meas(1'b0, 32'hffff_ffff, 32'd1);
    send_meas(1'b1, 32'd1, 32'hffff_ffff);
    send_meas(1'b0, 32'h8000_0000, 32'h7fff_ffff);
    send_meas(1'b1, 32'h7fff_ffff, 32'h8000_0000);
    send_meas(1'b0, 32'h0001_0000, 32'hffff_0000);
    send_meas(1'b1, 32'h0001_0000, 32'h0001_0000);
    send_meas(1'b0, 32'd0, 32'd0);
    send_meas(1'b1, 32'd0, 32'd0);
    drain();

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: write_all(32'd1, 32'd0, 32'd0, 32'd1, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
        1: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        2: write_all($urandom_range(1, 32'h0010_0000), $urandom_range(0, 32'h4_0000),
                     $urandom_range(0, 32'h4_0000), $urandom_range(1, 32'h0010_0000),
                     $urandom, $urandom_range(0, 32'h7fff_ffff),
                     $urandom_range(0, 32'h7fff_ffff), $urandom_range(0, 32'h7fff_ffff));
        3: write_all(32'd6554, 32'd655, 32'd6554, 32'd4096, 32'd51511, 32'd13435,
                     32'd13271, 32'd1638);
        default: write_all($urandom_range(1, 32'h0002_0000), $urandom_range(0, 32'h1000),
                           $urandom_range(0, 32'h1_0000), $urandom_range(1, 32'h1_0000),
                           $urandom, $urandom, $urandom, $urandom);
      endcase
      for (int n = 0; n < PhaseItems; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < PhaseItems; b++, n++) random_meas();
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 400));
      end
      drain();
    end

    $display("covered %0d measurement beats and %0d estimate beats over %0d register writes",
             sb.n_meas, sb.n_est, cfg_writes);
    $display("phases: extreme and random timing, noise and measurement variances; one long stall");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
